FILE: rtl/core/tpcw_pkg.sv
`timescale 1ns / 1ps
package tpcw_pkg;

  localparam int unsigned ScreenWidthDef  = 1280;
  localparam int unsigned ScreenHeightDef = 720;

  // edge / area values: 17b differences, product 34b, difference 35b
  localparam int unsigned EdgeW = 35;
  // |w| magnitude 32b, pair product 64b, numerator 35+64 = 99b, sum of three 101b
  localparam int unsigned MagW  = 32;
  localparam int unsigned PairW = 64;
  localparam int unsigned NumW  = 101;
  localparam int unsigned QW    = 16;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatOutside = 2'd1,
    StatInvalid = 2'd2
  } status_e;

  // per-item control carried down the pipe
  typedef struct packed {
    logic    covered;
    status_e status;
  } ctrl_t;

endpackage

FILE: rtl/core/tpcw_ratio_stage.sv
`timescale 1ns / 1ps
// One step of restoring division for the three weights: one quotient bit per
// stage, a shift, compare and subtract on the wide remainder.
module tpcw_ratio_stage
  import tpcw_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [2:0][NumW-1:0]   rem_i,
  input  logic [NumW-1:0]        den_i,
  input  logic [2:0][QW-1:0]     quo_i,
  output logic [2:0][NumW-1:0]   rem_o,
  output logic [2:0][QW-1:0]     quo_o
);

  logic [2:0][NumW:0]   shifted;
  logic [2:0][NumW-1:0] rem_d;
  logic [2:0][QW-1:0]   quo_d;
  logic [2:0][NumW-1:0] rem_q;
  logic [2:0][QW-1:0]   quo_q;

  // compare-and-subtract per lane
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i] = {rem_i[i], 1'b0};
      if (shifted[i] >= {1'b0, den_i}) begin
        rem_d[i] = NumW'(shifted[i] - {1'b0, den_i});
        quo_d[i] = {quo_i[i][QW-2:0], 1'b1};
      end else begin
        rem_d[i] = shifted[i][NumW-1:0];
        quo_d[i] = {quo_i[i][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

FILE: rtl/core/triangle_pixel_coverage_weights.sv
`timescale 1ns / 1ps
// Perspective-correct coverage weights, one pixel against one triangle.
// Input channel: vertex x/y (Q12.4), clip w (Q16.16) and a pixel position,
// handshake in_valid_i / in_stall_o. Output channel: covered, three Q1.15
// weights and a status code, handshake out_valid_o / out_stall_i.
// A request is taken at each edge with valid high and stall low.
// Throughput: one pixel per clock while the output is not stalled. The pipe
// registers are edge products, edge sums, |w| pairs, numerator products in two
// halves, denominator, classify, then 16 one-bit divide stages, rounding.
// The pipe is a chain of valid-tagged registers that all advance together;
// in_stall_o is high only when the output register is full and stalled, so
// a stalled receiver freezes the whole pipe and nothing is lost or repeated.
// Reset clears every valid bit; payload registers are not reset.
module triangle_pixel_coverage_weights
  import tpcw_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = ScreenWidthDef,
  parameter int unsigned SCREEN_HEIGHT = ScreenHeightDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] vert0_x_i,
  input  logic signed [15:0] vert0_y_i,
  input  logic signed [15:0] vert1_x_i,
  input  logic signed [15:0] vert1_y_i,
  input  logic signed [15:0] vert2_x_i,
  input  logic signed [15:0] vert2_y_i,
  input  logic signed [31:0] vert0_w_i,
  input  logic signed [31:0] vert1_w_i,
  input  logic signed [31:0] vert2_w_i,
  input  logic [10:0]        pixel_x_i,
  input  logic [9:0]         pixel_y_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               covered_o,
  output logic [15:0]        weight_0_o,
  output logic [15:0]        weight_1_o,
  output logic [15:0]        weight_2_o,
  output logic [1:0]         status_o
);

  localparam int unsigned NStages = 24;

  logic adv;
  logic [NStages-1:0] vld_q;
  assign adv        = !(vld_q[NStages-1] && out_stall_i);
  assign in_stall_o = !adv;

  // valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NStages-2:0], in_valid_i};
    end
  end

  // ---- stage 1: differences and edge products, screen bound
  logic signed [17:0] pxs, pys;
  logic signed [2:0][33:0] pa_q, pb_q;
  logic signed [33:0] aa_q, ab_q;
  logic [2:0][31:0] w1_q;
  logic off1_q;

  always_comb begin
    pxs = $signed({3'b000, pixel_x_i, 4'b0000});
    pys = $signed({4'b0000, pixel_y_i, 4'b0000});
  end

  always_ff @(posedge clk_i) begin
    logic signed [15:0] vx [3];
    logic signed [15:0] vy [3];
    logic signed [17:0] dx [3];
    logic signed [17:0] dy [3];
    if (adv) begin
      vx[0] = vert0_x_i; vx[1] = vert1_x_i; vx[2] = vert2_x_i;
      vy[0] = vert0_y_i; vy[1] = vert1_y_i; vy[2] = vert2_y_i;
      for (int i = 0; i < 3; i++) begin
        dx[i] = 18'(vx[i]) - pxs;
        dy[i] = 18'(vy[i]) - pys;
      end
      for (int i = 0; i < 3; i++) begin
        // edge i = dx[j]*dy[k] - dx[k]*dy[j]; differences fit 17 bits + sign
        pa_q[i] <= 34'(dx[(i+1)%3] * dy[(i+2)%3]);
        pb_q[i] <= 34'(dx[(i+2)%3] * dy[(i+1)%3]);
      end
      aa_q <= 34'((17'(vert1_x_i) - 17'(vert0_x_i)) * (17'(vert2_y_i) - 17'(vert0_y_i)));
      ab_q <= 34'((17'(vert2_x_i) - 17'(vert0_x_i)) * (17'(vert1_y_i) - 17'(vert0_y_i)));
      w1_q <= {vert2_w_i, vert1_w_i, vert0_w_i};
      off1_q <= (32'(pixel_x_i) >= SCREEN_WIDTH) || (32'(pixel_y_i) >= SCREEN_HEIGHT);
    end
  end

  // ---- stage 2: edge and area sums, |w| and signs
  logic signed [2:0][EdgeW-1:0] e2_q;
  logic signed [EdgeW-1:0] area2_q;
  logic [2:0][MagW-1:0] mag2_q;
  logic [2:0] neg2_q;
  logic wz2_q, off2_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        e2_q[i]   <= EdgeW'($signed(pa_q[i])) - EdgeW'($signed(pb_q[i]));
        mag2_q[i] <= w1_q[i][31] ? 32'(-w1_q[i]) : w1_q[i];
        neg2_q[i] <= w1_q[i][31];
      end
      area2_q <= EdgeW'(aa_q) - EdgeW'(ab_q);
      wz2_q   <= (w1_q[0] == '0) || (w1_q[1] == '0) || (w1_q[2] == '0);
      off2_q  <= off1_q;
    end
  end

  // ---- stage 3: coverage decision, |w_j|*|w_k| pairs
  logic [2:0][PairW-1:0] pair3_q;
  logic [2:0][EdgeW-2:0] e3_q;
  logic [2:0] neg3_q;
  logic cov3_q, wz3_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        pair3_q[i] <= PairW'(mag2_q[(i+1)%3]) * PairW'(mag2_q[(i+2)%3]);
        e3_q[i]    <= e2_q[i][EdgeW-2:0];
      end
      neg3_q <= neg2_q;
      wz3_q  <= wz2_q;
      cov3_q <= !off2_q && !area2_q[EdgeW-1] && (area2_q != '0) &&
                !e2_q[0][EdgeW-1] && !e2_q[1][EdgeW-1] && !e2_q[2][EdgeW-1];
    end
  end

  // ---- stages 4,5: e * pair in two 34x32 halves
  logic [2:0][EdgeW+31:0] lo4_q, hi4_q;
  logic [2:0] neg4_q;
  logic cov4_q, wz4_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        lo4_q[i] <= (EdgeW+32)'(e3_q[i]) * (EdgeW+32)'(pair3_q[i][31:0]);
        hi4_q[i] <= (EdgeW+32)'(e3_q[i]) * (EdgeW+32)'(pair3_q[i][63:32]);
      end
      neg4_q <= neg3_q;
      cov4_q <= cov3_q;
      wz4_q  <= wz3_q;
    end
  end

  logic signed [2:0][NumW-1:0] n5_q;
  logic cov5_q, wz5_q;

  always_ff @(posedge clk_i) begin
    logic [NumW-1:0] mag;
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        mag = NumW'(lo4_q[i]) + (NumW'(hi4_q[i]) << 32);
        n5_q[i] <= neg4_q[i] ? NumW'(-mag) : mag;
      end
      cov5_q <= cov4_q;
      wz5_q  <= wz4_q;
    end
  end

  // ---- stage 6: denominator
  logic signed [2:0][NumW-1:0] n6_q;
  logic signed [NumW-1:0] den6_q;
  logic cov6_q, wz6_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n6_q   <= n5_q;
      den6_q <= n5_q[0] + n5_q[1] + n5_q[2];
      cov6_q <= cov5_q;
      wz6_q  <= wz5_q;
    end
  end

  // ---- stage 7: classify each weight, seed the dividers
  logic [2:0][NumW-1:0] rem7_q;
  logic [NumW-1:0] den7_q;
  logic [2:0] zero7_q, full7_q;
  ctrl_t ctrl7_q;

  always_ff @(posedge clk_i) begin
    logic bad;
    if (adv) begin
      // uncovered pixels also get zero weights
      bad = !cov6_q || wz6_q || den6_q[NumW-1] || (den6_q == '0);
      for (int i = 0; i < 3; i++) begin
        zero7_q[i] <= n6_q[i][NumW-1] || (n6_q[i] == '0) || bad;
        full7_q[i] <= !bad && !n6_q[i][NumW-1] && (n6_q[i] >= den6_q);
        rem7_q[i]  <= n6_q[i];
      end
      den7_q <= den6_q;
      ctrl7_q.covered <= cov6_q;
      ctrl7_q.status  <= !cov6_q ? StatOutside : (bad ? StatInvalid : StatOk);
    end
  end

  // ---- stages 8..23: one quotient bit each
  logic [QW:0][2:0][NumW-1:0] rem_c;
  logic [QW:0][2:0][QW-1:0]   quo_c;
  logic [QW:0][NumW-1:0]      den_c;
  logic [QW:0][2:0]           zero_c, full_c;
  ctrl_t [QW:0]               ctrl_c;

  assign rem_c[0]  = rem7_q;
  assign quo_c[0]  = '0;
  assign den_c[0]  = den7_q;
  assign zero_c[0] = zero7_q;
  assign full_c[0] = full7_q;
  assign ctrl_c[0] = ctrl7_q;

  for (genvar s = 0; s < QW; s++) begin : g_div
    tpcw_ratio_stage u_stage (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (rem_c[s]),
      .den_i (den_c[s]),
      .quo_i (quo_c[s]),
      .rem_o (rem_c[s+1]),
      .quo_o (quo_c[s+1])
    );
    logic [NumW-1:0] den_q;
    logic [2:0] zero_q, full_q;
    ctrl_t ctrl_q;
    always_ff @(posedge clk_i) begin
      if (adv) begin
        den_q  <= den_c[s];
        zero_q <= zero_c[s];
        full_q <= full_c[s];
        ctrl_q <= ctrl_c[s];
      end
    end
    assign den_c[s+1]  = den_q;
    assign zero_c[s+1] = zero_q;
    assign full_c[s+1] = full_q;
    assign ctrl_c[s+1] = ctrl_q;
  end

  // ---- output register: round half up and select
  logic [2:0][15:0] wt_q;
  ctrl_t ctrl_out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        if (zero_c[QW][i]) wt_q[i] <= '0;
        else if (full_c[QW][i]) wt_q[i] <= 16'h8000;
        else wt_q[i] <= 16'((17'(quo_c[QW][i]) + 17'd1) >> 1);
      end
      ctrl_out_q <= ctrl_c[QW];
    end
  end

  assign out_valid_o = vld_q[NStages-1];
  assign covered_o   = ctrl_out_q.covered;
  assign status_o    = ctrl_out_q.status;
  assign weight_0_o  = wt_q[0];
  assign weight_1_o  = wt_q[1];
  assign weight_2_o  = wt_q[2];

  // stall only when the output holds a waiting request
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("stall without a waiting result");
  // uncovered results carry zero weights
  a_uncov_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !covered_o) |->
      (weight_0_o == '0 && weight_1_o == '0 && weight_2_o == '0))
    else $error("uncovered pixel with weights");
  // status agrees with coverage
  a_stat_cov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (covered_o == (status_o != StatOutside)))
    else $error("status and coverage disagree");
  // pipe freezes while stalled
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(weight_0_o)))
    else $error("output moved while stalled");

endmodule
